FILE: rtl/core/ddcb_pkg.sv
// Package for the decimating DC blocker: widths, reset values and register map.
// No dependencies; imported by decimating_dc_blocker_unit.
`default_nettype none

package ddcb_pkg;

    localparam int ADC_BITS  = 12;
    localparam int ACC_BITS  = ADC_BITS + 16;
    localparam int RES_BITS  = ADC_BITS + 1;
    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int S_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam int DEC_BITS   = 8;
    localparam int SHIFT_BITS = 5;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL    = 2;  // paddr bit that picks the register

    localparam logic [DEC_BITS-1:0]   DEC_RESET   = 8'd1;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 5'd8;
    localparam logic [SHIFT_BITS-1:0] SHIFT_MAX   = 5'd16;

    localparam logic [ACC_BITS-1:0] CONV_MID =
        ACC_BITS'(1) << (ADC_BITS - 1);
    localparam logic [ACC_BITS-1:0] ACC_RESET = CONV_MID << SHIFT_RESET;
    localparam logic [ADC_BITS-1:0] SAMPLE_MAX = '1;

    typedef enum logic {
        CFG_DECIMATION = 1'b0,
        CFG_SHIFT      = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/core/decimating_dc_blocker_unit.sv
// Decimating DC blocker top level: decimation counter, leaky-integrator DC
// estimate and residual output with an APB-style register port. Uses ddcb_pkg.
`default_nettype none

// Usage
//   s_* channel carries raw unsigned converter samples (s_tdata[11:0]).
//   m_* channel carries signed residuals (m_tdata[12:0], two's complement).
//   One sample in every N (the decimation register) is kept, starting with
//   the first sample after reset or after a decimation register write;
//   dropped samples give no result and leave the DC estimate alone.
//   Path: a kept sample passes the input register, then the result
//   register, and is then presented on m_*.
//   Throughput: one sample per cycle while the receiver does not stall; the
//   combinational accumulator update (subtract, add, shift) between the two registers allows this.
//   When the receiver stalls, the result register holds and s_tready stays
//   high until the input register also holds a kept sample.
//   Reset (aresetn low, synchronous) empties both registers, sets the
//   decimation ratio to 1, the estimator shift to 8 and seeds the
//   accumulator with the converter midpoint shifted left by 8.
//   Registers: 0x0 decimation ratio [7:0], 0x4 estimator shift [4:0];
//   write only while the block is idle.
module decimating_dc_blocker_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [11:0] adc_sample
    input  wire logic [ddcb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [12:0] residual_sample
    output logic [ddcb_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ddcb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import ddcb_pkg::*;

    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;
    logic [DEC_BITS-1:0]   skip_reg, skip_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                  in_valid_reg, in_valid_next;
    logic [ADC_BITS-1:0]   in_sample_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [RES_BITS-1:0]   out_res_reg;
    logic [RES_BITS-1:0]   res_next;

    logic                  cfg_wr;
    cfg_idx_t              cfg_idx;
    logic                  s_accept;
    logic                  out_free;
    logic                  acc_load;
    logic                  keep;
    logic [DEC_BITS-1:0]   dec_eff;
    logic [DEC_BITS:0]     skip_inc;
    logic [SHIFT_BITS-1:0] shift_eff;
    logic [ACC_BITS-1:0]   est_old, est_new;
    logic [DIFF_BITS-1:0]  diff;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[REG_SEL]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            CFG_DECIMATION: prdata = {{(32-DEC_BITS){1'b0}}, dec_reg};
            CFG_SHIFT:      prdata = {{(32-SHIFT_BITS){1'b0}}, shift_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        dec_next   = dec_reg;
        shift_next = shift_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                CFG_DECIMATION: dec_next   = pwdata[DEC_BITS-1:0];
                CFG_SHIFT:      shift_next = pwdata[SHIFT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = out_free || !in_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign acc_load = in_valid_reg && out_free;

    // ---------------- decimation ----------------
    assign dec_eff  = (dec_reg == '0) ? DEC_BITS'(1) : dec_reg;
    assign keep     = (skip_reg == '0);
    assign skip_inc = {1'b0, skip_reg} + (DEC_BITS+1)'(1);

    always_comb begin
        skip_next = skip_reg;
        if (cfg_wr && cfg_idx == CFG_DECIMATION) begin
            skip_next = '0;
        end else if (s_accept) begin
            if (skip_inc >= {1'b0, dec_eff}) begin
                skip_next = '0;
            end else begin
                skip_next = skip_inc[DEC_BITS-1:0];
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = keep;
        end else if (acc_load) begin
            in_valid_next = 1'b0;
        end
    end

    // ---------------- DC estimate and residual ----------------
    assign shift_eff = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    assign est_old   = acc_reg >> shift_eff;
    assign acc_next  = acc_reg - est_old + {{(ACC_BITS-ADC_BITS){1'b0}}, in_sample_reg};
    assign est_new   = acc_next >> shift_eff;
    assign diff      = {{(DIFF_BITS-ADC_BITS){1'b0}}, in_sample_reg} - {1'b0, est_new};

    // clamp to +-SAMPLE_MAX
    always_comb begin
        if ($signed(diff) < -$signed({{(DIFF_BITS-ADC_BITS){1'b0}}, SAMPLE_MAX})) begin
            res_next = -{1'b0, SAMPLE_MAX};
        end else if ($signed(diff) > $signed({{(DIFF_BITS-ADC_BITS){1'b0}}, SAMPLE_MAX})) begin
            res_next = {1'b0, SAMPLE_MAX};
        end else begin
            res_next = diff[RES_BITS-1:0];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (acc_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_BITS){1'b0}}, out_res_reg};

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg       <= DEC_RESET;
            shift_reg     <= SHIFT_RESET;
            skip_reg      <= '0;
            acc_reg       <= ACC_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            dec_reg       <= dec_next;
            shift_reg     <= shift_next;
            skip_reg      <= skip_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (acc_load) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_tdata[ADC_BITS-1:0];
        end
        if (acc_load) begin
            out_res_reg <= res_next;
        end
    end

    // ---------------- assertions ----------------
    a_drop_no_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (skip_reg != '0) |=> !in_valid_reg)
        else $error("dropped sample entered the input register");

    a_skip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg < dec_eff)
        else $error("decimation counter out of range");

    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc_load |=> $stable(acc_reg))
        else $error("accumulator moved without a kept sample");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result raised without a kept sample");

endmodule

`default_nettype wire

FILE: bench/decimating_dc_blocker_unit_tb.sv
// Self-checking bench for decimating_dc_blocker_unit: directed and random sample streams,
// register writes through the APB-style port, results checked against an in-bench predictor.
// Depends on ddcb_pkg and the decimating_dc_blocker_unit RTL.
module decimating_dc_blocker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddcb_pkg::*;

    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    typedef logic signed [RES_BITS-1:0] residual_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor copy of the block's registers and state
    logic [DEC_BITS-1:0]   blk_dec;
    logic [SHIFT_BITS-1:0] blk_shift;
    logic [ACC_BITS-1:0]   blk_acc;
    logic [DEC_BITS-1:0]   blk_skip;

    residual_t residual_q[$];
    int        err_count;
    bit        src_idle_on;
    bit        sink_idle_on;

    decimating_dc_blocker_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("decimating_dc_blocker_unit verification failed");
        $finish;
    end

    task automatic log_error(input string what, input int expected, input int actual);
        if (err_count < MAX_REPORTS) begin
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, expected, actual);
        end
        err_count++;
    endtask

    // Leaky integrator: update on kept samples only, then queue the residual.
    function automatic void predict_residual(input logic [ADC_BITS-1:0] x);
        logic [DEC_BITS-1:0]   d;
        logic [SHIFT_BITS-1:0] s;
        bit                    kept;
        longint                r;
        d = (blk_dec == '0) ? DEC_BITS'(1) : blk_dec;
        s = (blk_shift > SHIFT_MAX) ? SHIFT_MAX : blk_shift;
        kept = (blk_skip == '0);
        if (int'(blk_skip) + 1 >= int'(d)) begin
            blk_skip = '0;
        end else begin
            blk_skip = blk_skip + 1'b1;
        end
        if (kept) begin
            blk_acc = ACC_BITS'(blk_acc - (blk_acc >> s) + x);
            r = longint'(x) - longint'(blk_acc >> s);
            if (r > longint'(SAMPLE_MAX)) r = longint'(SAMPLE_MAX);
            if (r < -longint'(SAMPLE_MAX)) r = -longint'(SAMPLE_MAX);
            residual_q.push_back(RES_BITS'(r));
        end
    endfunction

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin : check_results
        residual_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (residual_q.size() == 0) begin
                log_error("unexpected residual", 0, int'($signed(m_tdata[RES_BITS-1:0])));
            end else begin
                want = residual_q.pop_front();
                if (m_tdata[RES_BITS-1:0] !== want) begin
                    log_error("residual mismatch", int'(want),
                              int'($signed(m_tdata[RES_BITS-1:0])));
                end
            end
        end
    end

    // Result-side backpressure in random bursts.
    initial begin : sink_stall
        int stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [ADC_BITS-1:0] x);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(x);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_residual(x);
    endtask

    // Hold the input side until every predicted residual has come back or DRAIN_LIMIT runs out.
    task automatic wait_drained();
        int spin;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        spin = 0;
        while (residual_q.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_read(input cfg_idx_t idx, output logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx) << REG_SEL;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write(input cfg_idx_t idx, input logic [31:0] value);
        logic [31:0] rd;
        wait_drained();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_SEL;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == CFG_DECIMATION) begin
            blk_dec  = value[DEC_BITS-1:0];
            blk_skip = '0;
        end else begin
            blk_shift = value[SHIFT_BITS-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_read(idx, rd);
        if (idx == CFG_DECIMATION) begin
            if (rd[DEC_BITS-1:0] !== value[DEC_BITS-1:0])
                log_error("decimation readback", int'(value[DEC_BITS-1:0]),
                          int'(rd[DEC_BITS-1:0]));
        end else begin
            if (rd[SHIFT_BITS-1:0] !== value[SHIFT_BITS-1:0])
                log_error("shift readback", int'(value[SHIFT_BITS-1:0]),
                          int'(rd[SHIFT_BITS-1:0]));
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] rd;
        apb_read(CFG_DECIMATION, rd);
        if (rd[DEC_BITS-1:0] !== DEC_RESET)
            log_error("decimation after reset", int'(DEC_RESET), int'(rd[DEC_BITS-1:0]));
        apb_read(CFG_SHIFT, rd);
        if (rd[SHIFT_BITS-1:0] !== SHIFT_RESET)
            log_error("shift after reset", int'(SHIFT_RESET), int'(rd[SHIFT_BITS-1:0]));
    endtask

    task automatic test_sample_extremes();
        send_sample(12'd0);
        send_sample(SAMPLE_MAX);
        send_sample(12'd2048);
        send_sample(SAMPLE_MAX);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(SAMPLE_MAX - 1'b1);
    endtask

    task automatic test_decimation_modes();
        // zero factor keeps every sample
        apb_write(CFG_DECIMATION, 32'd0);
        repeat (3) send_sample(ADC_BITS'($urandom));
        apb_write(CFG_DECIMATION, 32'd3);
        repeat (7) send_sample(ADC_BITS'($urandom));
        // rewrite mid-count: the next sample is kept again
        apb_write(CFG_DECIMATION, 32'd3);
        repeat (2) send_sample(ADC_BITS'($urandom));
    endtask

    task automatic test_shift_modes();
        // shift drop on a large accumulator drives the residual into saturation
        apb_write(CFG_SHIFT, 32'd1);
        send_sample(12'd0);
        send_sample(SAMPLE_MAX);
        // zero shift: estimate follows the sample
        apb_write(CFG_SHIFT, 32'd0);
        send_sample(12'd1234);
        send_sample(SAMPLE_MAX);
        // shift above sixteen clamps
        apb_write(CFG_SHIFT, 32'd31);
        send_sample(12'd77);
        apb_write(CFG_SHIFT, 32'(SHIFT_RESET));
        apb_write(CFG_DECIMATION, 32'(DEC_RESET));
    endtask

    task automatic test_random_phases(input int n_phases, input int n_items);
        int mode;
        int level;
        int x;
        int pick;
        for (int ph = 0; ph < n_phases; ph++) begin
            pick = $urandom_range(0, 9);
            if (ph == 1)       apb_write(CFG_DECIMATION, 32'd255);
            else if (pick < 6) apb_write(CFG_DECIMATION, 32'($urandom_range(1, 6)));
            else if (pick < 8) apb_write(CFG_DECIMATION, 32'($urandom_range(7, 40)));
            else if (pick < 9) apb_write(CFG_DECIMATION, 32'd0);
            if ($urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)      apb_write(CFG_SHIFT, 32'($urandom_range(1, 16)));
                else if (pick < 7) apb_write(CFG_SHIFT, 32'd1);
                else if (pick < 8) apb_write(CFG_SHIFT, 32'd16);
                else if (pick < 9) apb_write(CFG_SHIFT, 32'd0);
                else               apb_write(CFG_SHIFT, 32'($urandom_range(17, 31)));
            end
            mode  = $urandom_range(0, 3);
            level = $urandom_range(0, 4095);
            for (int k = 0; k < n_items; k++) begin
                case (mode)
                    0: x = $urandom_range(0, 4095);
                    1: x = level + $urandom_range(0, 128) - 64;
                    2: x = ($urandom_range(0, 1) != 0) ? 4095 : 0;
                    default: x = ((k / 16) % 2 != 0) ? level : 4095 - level;
                endcase
                if (x < 0) x = 0;
                if (x > 4095) x = 4095;
                send_sample(ADC_BITS'(x));
                if (ph % 2 == 0 && k == n_items / 2) wait_drained();
            end
        end
    endtask

    task automatic test_clean_stream(input int n_items);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        apb_write(CFG_DECIMATION, 32'd2);
        apb_write(CFG_SHIFT, 32'd4);
        for (int k = 0; k < n_items; k++) send_sample(ADC_BITS'($urandom));
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        err_count    = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        blk_dec   = DEC_RESET;
        blk_shift = SHIFT_RESET;
        blk_acc   = ACC_RESET;
        blk_skip  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_reset();
        test_sample_extremes();
        test_decimation_modes();
        test_shift_modes();
        test_random_phases(7, 100);
        test_clean_stream(100);

        wait_drained();
        if (err_count == 0 && residual_q.size() == 0) begin
            $display("decimating_dc_blocker_unit verification clean");
        end else begin
            $display("decimating_dc_blocker_unit verification failed");
        end
        $finish;
    end

endmodule
